[sv/swv_pkg.sv]
// ----------------------------------------------------------------------------
// swv_pkg
// Shared types and constants for the wall visibility check block.
// ----------------------------------------------------------------------------
`default_nettype none

package swv_pkg;

	// fixed widths of the transaction fields
	localparam int FIELD_W = 16;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	// command codes
	localparam logic CMD_WALL  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} swv_state_t;

	// tag that travels with each wall read
	typedef struct packed {
		logic valid;
		logic last;
	} swv_tag_t;

	// per-wall result leaving the test pipeline
	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} swv_result_t;

endpackage

`default_nettype wire

[sv/swv_wall_mem.sv]
// ----------------------------------------------------------------------------
// swv_wall_mem
// Wall store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swv_wall_mem #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 64,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/swv_isect_pipe.sv]
// ----------------------------------------------------------------------------
// swv_isect_pipe
// Pipelined exact segment crossing test, one stored wall per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swv_isect_pipe #(
	parameter int CW = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire swv_pkg::swv_tag_t          issue,
	input  wire logic        [4*CW-1:0]     wall_data,
	input  wire logic signed [CW-1:0]       ax,
	input  wire logic signed [CW-1:0]       ay,
	input  wire logic signed [CW:0]         dx,
	input  wire logic signed [CW:0]         dy,
	output swv_pkg::swv_result_t            result
);

	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;

	swv_pkg::swv_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic              hit_s5, valid_s5, last_s5;

	logic signed [CW-1:0] wx1, wy1, wx2, wy2;
	logic signed [DW-1:0] ex_s2, ey_s2, p_s2, q_s2;
	logic signed [PW-1:0] ex_dy_s3, ey_dx_s3, dx_p_s3, dy_q_s3, ex_p_s3, ey_q_s3;
	logic signed [SW-1:0] den_s4, nl_s4, ng_s4;
	logic                 lam_ok, gam_ok;

	// wall endpoints from the store word
	assign wx1 = wall_data[CW-1:0];
	assign wy1 = wall_data[2*CW-1:CW];
	assign wx2 = wall_data[3*CW-1:2*CW];
	assign wy2 = wall_data[4*CW-1:3*CW];

	// tag shift, aligned with the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1   <= '0;
			tag_s2   <= '0;
			tag_s3   <= '0;
			tag_s4   <= '0;
			valid_s5 <= 1'b0;
			last_s5  <= 1'b0;
		end else begin
			tag_s1   <= issue;
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			tag_s4   <= tag_s3;
			valid_s5 <= tag_s4.valid;
			last_s5  <= tag_s4.last;
		end
	end

	// stage 2: wall direction and offsets to the query start
	always_ff @(posedge clk) begin
		ex_s2 <= DW'(wx2) - DW'(wx1);
		ey_s2 <= DW'(wy2) - DW'(wy1);
		p_s2  <= DW'(wy1) - DW'(ay);
		q_s2  <= DW'(ax) - DW'(wx1);
	end

	// stage 3: six independent products
	always_ff @(posedge clk) begin
		ex_dy_s3 <= PW'(ex_s2) * PW'(dy);
		ey_dx_s3 <= PW'(ey_s2) * PW'(dx);
		dx_p_s3  <= PW'(dx) * PW'(p_s2);
		dy_q_s3  <= PW'(dy) * PW'(q_s2);
		ex_p_s3  <= PW'(ex_s2) * PW'(p_s2);
		ey_q_s3  <= PW'(ey_s2) * PW'(q_s2);
	end

	// stage 4: determinant and the two numerators
	always_ff @(posedge clk) begin
		den_s4 <= SW'(ex_dy_s3) - SW'(ey_dx_s3);
		nl_s4  <= SW'(dx_p_s3) + SW'(dy_q_s3);
		ng_s4  <= SW'(ex_p_s3) + SW'(ey_q_s3);
	end

	// num/den within [0,1], ends included, by sign and magnitude
	always_comb begin
		if (!den_s4[SW-1]) begin
			lam_ok = !nl_s4[SW-1] && (nl_s4 <= den_s4);
			gam_ok = !ng_s4[SW-1] && (ng_s4 <= den_s4);
		end else begin
			lam_ok = (nl_s4 <= 0) && (nl_s4 >= den_s4);
			gam_ok = (ng_s4 <= 0) && (ng_s4 >= den_s4);
		end
	end

	// stage 5: crossing decision, parallel pairs never cross
	always_ff @(posedge clk) begin
		hit_s5 <= (den_s4 != '0) && lam_ok && gam_ok;
	end

	assign result.valid = valid_s5;
	assign result.last  = last_s5;
	assign result.hit   = hit_s5;

endmodule

`default_nettype wire

[sv/segment_wall_visibility_check.sv]
// Sequence: a wall write lands in the store when taken. A query streams the first
// min(wall_count, MAX_WALLS) walls (none for a count of 0) through the pipeline and
// presents its answer once the result register is free. Throughput: one query at a
// time, the next item taken while the answer is shown; one stored wall tested per cycle.
// Reset: arst_n clears wall_count and the control state; the wall store is
// not cleared, a slot holds garbage until it is written.
// ----------------------------------------------------------------------------
// segment_wall_visibility_check
// Stores wall segments and tests a query segment against the first
// min(wall_count, MAX_WALLS) walls; visible is high when no checked wall crosses it.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_wall_visibility_check #(
	parameter int MAX_WALLS  = 64,
	parameter int COORD_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// item channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                cmd,
	input  wire logic [swv_pkg::INDEX_W-1:0]         wall_index,
	input  wire logic signed [swv_pkg::FIELD_W-1:0]  seg_ax,
	input  wire logic signed [swv_pkg::FIELD_W-1:0]  seg_ay,
	input  wire logic signed [swv_pkg::FIELD_W-1:0]  seg_bx,
	input  wire logic signed [swv_pkg::FIELD_W-1:0]  seg_by,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     visible,
	// configuration channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [swv_pkg::COUNT_W-1:0]         cfg_data
);

	localparam int CW     = (COORD_BITS > swv_pkg::FIELD_W) ? swv_pkg::FIELD_W : COORD_BITS;
	localparam int DW     = CW + 1;
	localparam int AW     = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int WORD_W = 4 * CW;

	swv_pkg::swv_state_t  state_q;
	swv_pkg::swv_tag_t    issue;
	swv_pkg::swv_result_t pres;

	logic [swv_pkg::COUNT_W-1:0] wall_count_q;
	logic [AW-1:0]               idx_q, last_idx_q;
	logic                        vis_q, out_valid_q, visible_q;
	logic signed [CW-1:0]        ax_q, ay_q;
	logic signed [DW-1:0]        dx_q, dy_q;

	logic signed [CW-1:0] ax_c, ay_c, bx_c, by_c;
	logic                 in_fire, out_fire, wr_en, q_start, out_free;
	logic [31:0]          cnt_ext, n_clip;
	logic [WORD_W-1:0]    wdata, rdata;

	// coordinates at the configured width
	assign ax_c = seg_ax[CW-1:0];
	assign ay_c = seg_ay[CW-1:0];
	assign bx_c = seg_bx[CW-1:0];
	assign by_c = seg_by[CW-1:0];

	// handshakes
	assign in_ready  = (state_q == swv_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign q_start   = in_fire && (cmd == swv_pkg::CMD_QUERY);

	// wall write, out-of-range slots dropped
	assign wr_en = in_fire && (cmd == swv_pkg::CMD_WALL)
		&& (32'(wall_index) < 32'(MAX_WALLS));
	assign wdata = {by_c, bx_c, ay_c, ax_c};

	// walls checked per query, capped at the store depth
	assign cnt_ext = 32'(wall_count_q);
	assign n_clip  = (cnt_ext > 32'(MAX_WALLS)) ? 32'(MAX_WALLS) : cnt_ext;

	// read issue
	assign issue.valid = (state_q == swv_pkg::ST_RUN);
	assign issue.last  = (state_q == swv_pkg::ST_RUN) && (idx_q == last_idx_q);

	swv_wall_mem #(
		.DEPTH  (MAX_WALLS),
		.DATA_W (WORD_W),
		.ADDR_W (AW)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(wall_index)),
		.wdata (wdata),
		.re    (issue.valid),
		.raddr (idx_q),
		.rdata (rdata)
	);

	swv_isect_pipe #(
		.CW (CW)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.wall_data (rdata),
		.ax        (ax_q),
		.ay        (ay_q),
		.dx        (dx_q),
		.dy        (dy_q),
		.result    (pres)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			wall_count_q <= cfg_data;
		end
	end

	// query operands, held while the walls stream through
	always_ff @(posedge clk) begin
		if (q_start) begin
			ax_q       <= ax_c;
			ay_q       <= ay_c;
			dx_q       <= DW'(bx_c) - DW'(ax_c);
			dy_q       <= DW'(by_c) - DW'(ay_c);
			last_idx_q <= AW'(n_clip - 32'd1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swv_pkg::ST_IDLE;
			idx_q   <= '0;
			vis_q   <= 1'b1;
		end else begin
			unique case (state_q)
				swv_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (q_start) begin
						vis_q   <= 1'b1;
						state_q <= (wall_count_q == '0) ? swv_pkg::ST_DONE
							: swv_pkg::ST_RUN;
					end
				end
				swv_pkg::ST_RUN: begin
					idx_q <= idx_q + AW'(1);
					if (pres.valid && pres.hit) begin
						vis_q <= 1'b0;
					end
					if (issue.last) begin
						state_q <= swv_pkg::ST_DRAIN;
					end
				end
				swv_pkg::ST_DRAIN: begin
					if (pres.valid && pres.hit) begin
						vis_q <= 1'b0;
					end
					if (pres.valid && pres.last) begin
						state_q <= swv_pkg::ST_DONE;
					end
				end
				swv_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= swv_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= swv_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == swv_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == swv_pkg::ST_DONE && out_free) begin
			visible_q <= vis_q;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_pipe_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		pres.valid |-> (state_q == swv_pkg::ST_RUN || state_q == swv_pkg::ST_DRAIN))
		else $error("wall result outside a query");

	a_wall_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == swv_pkg::CMD_WALL) |=> (state_q == swv_pkg::ST_IDLE))
		else $error("wall write left the idle state");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swv_pkg::ST_DONE && out_free) |=> (out_valid && state_q == swv_pkg::ST_IDLE))
		else $error("finished query not presented");

	a_hit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pres.valid && pres.hit) |=> !vis_q)
		else $error("crossing wall did not clear visibility");

endmodule

`default_nettype wire
